// ----- design/rid_pkg.sv -----
// ----------------------------------------------------------------------------
// rid_pkg
// Shared types and codes of the rounding integer divider.
// ----------------------------------------------------------------------------
package rid_pkg;

  // Rounding mode register codes
  localparam logic [1:0] RM_NEAREST_EVEN = 2'd0;
  localparam logic [1:0] RM_TOWARD_ZERO  = 2'd1;
  localparam logic [1:0] RM_TOWARD_POS   = 2'd2;
  localparam logic [1:0] RM_TOWARD_NEG   = 2'd3;

  // Width of the shift amount field
  localparam int unsigned SHIFT_W = 6;

  // Side information that travels with each word down the pipeline
  typedef struct packed {
    logic neg;  // sign of the represented value
    logic dbz;  // divisor was zero
  } rid_tag_t;

endpackage

// ----- design/rounding_integer_divider.sv -----
// ----------------------------------------------------------------------------
// rounding_integer_divider
// Pipelined unsigned divider with configurable IEEE rounding of the quotient.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                         | Direction
//  ---------+-----------------------------------------------+----------
//  in       | in_valid/in_ready, in_dividend, in_divisor,   | sink
//           | in_value_negative, in_shift_enable,           |
//           | in_shift_amount                               |
//  out      | out_valid/out_ready, out_quotient,            | source
//           | out_divide_by_zero                            |
//  cfg      | cfg_valid/cfg_ready, cfg_rounding_mode        | sink
//
//  Takes one word per cycle unless the pipeline is full and stalled. Stages,
//  in order: one input stage for the shift, one restoring step per quotient
//  bit, one rounding stage that is also the output register.
//  rst_n (synchronous, active low) empties every stage and sets the
//  rounding mode to nearest even.
//  Each stage holds its word while the next one is full and stalled; empty
//  stages still fill, so words keep entering while a result waits.
//  cfg_ready is always high; write the mode only while the block is idle.
// ----------------------------------------------------------------------------
module rounding_integer_divider
  import rid_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_dividend,
  input  logic [DATA_WIDTH-1:0] in_divisor,
  input  logic                  in_value_negative,
  input  logic                  in_shift_enable,
  input  logic [SHIFT_W-1:0]    in_shift_amount,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_quotient,
  output logic                  out_divide_by_zero,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_rounding_mode
);

  localparam int unsigned W = DATA_WIDTH;

  logic [1:0] mode_r;

  // Stage links: index 0 is the input stage output, index W the last step
  logic         v_a   [0:W];
  logic         rdy_a [0:W];
  logic [W-1:0] rem_a [0:W];
  logic [W-1:0] num_a [0:W];
  logic [W-1:0] den_a [0:W];
  rid_tag_t     tag_a [0:W];

  // Rounding mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RM_NEAREST_EVEN;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_rounding_mode;
    end
  end

  // Shift and zero-divisor detection
  rid_prep_stage #(.W(W)) u_prep (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (in_valid),
    .up_ready       (in_ready),
    .dividend       (in_dividend),
    .divisor        (in_divisor),
    .value_negative (in_value_negative),
    .shift_enable   (in_shift_enable),
    .shift_amount   (in_shift_amount),
    .dn_valid       (v_a[0]),
    .dn_ready       (rdy_a[0]),
    .num            (num_a[0]),
    .den            (den_a[0]),
    .tag            (tag_a[0])
  );

  // Partial remainder starts at zero
  assign rem_a[0] = '0;

  // One quotient bit per stage, most significant first
  for (genvar i = 0; i < W; i++) begin : g_step
    rid_div_step #(.W(W)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v_a[i]),
      .up_ready (rdy_a[i]),
      .rem_in   (rem_a[i]),
      .num_in   (num_a[i]),
      .den_in   (den_a[i]),
      .tag_in   (tag_a[i]),
      .dn_valid (v_a[i+1]),
      .dn_ready (rdy_a[i+1]),
      .rem_out  (rem_a[i+1]),
      .num_out  (num_a[i+1]),
      .den_out  (den_a[i+1]),
      .tag_out  (tag_a[i+1])
    );
  end

  // Rounding and result register; num now holds the truncated quotient
  rid_round_stage #(.W(W)) u_round (
    .clk            (clk),
    .rst_n          (rst_n),
    .mode           (mode_r),
    .up_valid       (v_a[W]),
    .up_ready       (rdy_a[W]),
    .quo            (num_a[W]),
    .rem            (rem_a[W]),
    .den            (den_a[W]),
    .tag            (tag_a[W]),
    .dn_valid       (out_valid),
    .dn_ready       (out_ready),
    .quotient       (out_quotient),
    .divide_by_zero (out_divide_by_zero)
  );

endmodule

// ----- design/rid_prep_stage.sv -----
// ----------------------------------------------------------------------------
// rid_prep_stage
// Input stage: applies the optional left shift and flags a zero divisor.
// ----------------------------------------------------------------------------
module rid_prep_stage
  import rid_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [W-1:0]       dividend,
  input  logic [W-1:0]       divisor,
  input  logic               value_negative,
  input  logic               shift_enable,
  input  logic [SHIFT_W-1:0] shift_amount,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic [W-1:0]       num,
  output logic [W-1:0]       den,
  output rid_tag_t           tag
);

  logic           v_r;
  logic [W-1:0]   num_r, num_nxt;
  logic [W-1:0]   den_r;
  rid_tag_t       tag_r, tag_nxt;

  assign up_ready = !v_r || dn_ready;

  // Bits shifted out above the top are dropped
  assign num_nxt = shift_enable ? (dividend << shift_amount) : dividend;

  always_comb begin
    tag_nxt.neg = value_negative;
    tag_nxt.dbz = (divisor == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      num_r <= num_nxt;
      den_r <= divisor;
      tag_r <= tag_nxt;
    end
  end

  assign dn_valid = v_r;
  assign num      = num_r;
  assign den      = den_r;
  assign tag      = tag_r;

endmodule

// ----- design/rid_div_step.sv -----
// ----------------------------------------------------------------------------
// rid_div_step
// One restoring division step: settles one quotient bit per stage.
// ----------------------------------------------------------------------------
module rid_div_step
  import rid_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] num_in,
  input  logic [W-1:0] den_in,
  input  rid_tag_t     tag_in,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] num_out,
  output logic [W-1:0] den_out,
  output rid_tag_t     tag_out
);

  logic         v_r;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] num_r, num_nxt;
  logic [W-1:0] den_r;
  rid_tag_t     tag_r;
  logic [W:0]   trial;
  logic [W-1:0] diff;
  logic         qbit;

  assign up_ready = !v_r || dn_ready;

  // Bring down the next dividend bit, subtract if it fits; when it fits the
  // difference is below the divisor, so the low bits alone carry it
  assign trial   = {rem_in, num_in[W-1]};
  assign diff    = trial[W-1:0] - den_in;
  assign qbit    = (trial >= {1'b0, den_in});
  assign rem_nxt = qbit ? diff : trial[W-1:0];
  assign num_nxt = {num_in[W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      den_r <= den_in;
      tag_r <= tag_in;
    end
  end

  assign dn_valid = v_r;
  assign rem_out  = rem_r;
  assign num_out  = num_r;
  assign den_out  = den_r;
  assign tag_out  = tag_r;

endmodule

// ----- design/rid_round_stage.sv -----
// ----------------------------------------------------------------------------
// rid_round_stage
// Output stage: applies the rounding increment and the divide-by-zero result.
// ----------------------------------------------------------------------------
module rid_round_stage
  import rid_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   mode,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] quo,
  input  logic [W-1:0] rem,
  input  logic [W-1:0] den,
  input  rid_tag_t     tag,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] quotient,
  output logic         divide_by_zero
);

  logic         v_r;
  logic [W-1:0] q_r, q_nxt;
  logic         dbz_r;
  logic [W:0]   twice;
  logic         inexact;
  logic         inc;

  assign up_ready = !v_r || dn_ready;

  // Compare twice the remainder at full width so it never wraps
  assign twice   = {rem, 1'b0};
  assign inexact = (rem != '0);

  always_comb begin
    inc = 1'b0;
    unique case (mode)
      RM_NEAREST_EVEN: begin
        inc = (twice > {1'b0, den}) || ((twice == {1'b0, den}) && quo[0]);
      end
      RM_TOWARD_ZERO: begin
        inc = 1'b0;
      end
      RM_TOWARD_POS: begin
        inc = !tag.neg;
      end
      RM_TOWARD_NEG: begin
        inc = tag.neg;
      end
      default: begin
        inc = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (tag.dbz) begin
      q_nxt = '1;
    end else begin
      q_nxt = quo + {{(W-1){1'b0}}, inc && inexact};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      q_r   <= q_nxt;
      dbz_r <= tag.dbz;
    end
  end

  assign dn_valid       = v_r;
  assign quotient       = q_r;
  assign divide_by_zero = dbz_r;

endmodule

// ----- tb/sv/rounding_integer_divider_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rounding_integer_divider_tb
// Self-checking bench for the pipelined rounding integer divider: operand
// words go in under every rounding mode, and each quotient that comes back is
// compared with one worked out alongside.
// ----------------------------------------------------------------------------
module rounding_integer_divider_tb;
  import rid_pkg::*;

  localparam int unsigned DW          = 64;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_WORDS = 322;
  localparam int unsigned LONG_HOLD   = 400;

  // One operand word as it enters the block
  typedef struct {
    logic [DW-1:0]      dividend;
    logic [DW-1:0]      divisor;
    logic               neg;
    logic               shen;
    logic [SHIFT_W-1:0] sh;
  } operand_word_t;

  // One quotient word as it should leave the block
  typedef struct {
    logic [DW-1:0] quotient;
    logic          dbz;
  } quotient_word_t;

  // Holds the mode the block was last given and the quotients still owed
  class quotient_ledger;
    logic [1:0]     rounding_mode;
    quotient_word_t owed[$];
    int unsigned    mismatches;

    function new();
      rounding_mode = RM_NEAREST_EVEN;
      mismatches    = 0;
    endfunction

    function quotient_word_t round_quotient(operand_word_t w);
      quotient_word_t res;
      logic [DW-1:0]  num;
      logic [DW-1:0]  q;
      logic [DW-1:0]  rem;
      logic [DW:0]    twice_rem;
      logic           bump;
      num = w.shen ? (w.dividend << w.sh) : w.dividend;
      if (w.divisor == '0) begin
        res.quotient = '1;
        res.dbz      = 1'b1;
        return res;
      end
      q         = num / w.divisor;
      rem       = num % w.divisor;
      twice_rem = {rem, 1'b0};
      bump      = 1'b0;
      if (rem != '0) begin
        case (rounding_mode)
          RM_NEAREST_EVEN: begin
            bump = (twice_rem > {1'b0, w.divisor}) ||
                   (twice_rem == {1'b0, w.divisor} && q[0]);
          end
          RM_TOWARD_ZERO: begin
            bump = 1'b0;
          end
          RM_TOWARD_POS: begin
            bump = !w.neg;
          end
          default: begin
            bump = w.neg;
          end
        endcase
      end
      res.quotient = q + {{(DW-1){1'b0}}, bump};
      res.dbz      = 1'b0;
      return res;
    endfunction

    function void note_operands(operand_word_t w);
      owed.push_back(round_quotient(w));
    endfunction

    function void check_quotient(logic [DW-1:0] quotient, logic dbz);
      quotient_word_t want;
      if (owed.size() == 0) begin
        $error("unexpected result word: quotient %h divide_by_zero %b", quotient, dbz);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (quotient !== want.quotient) begin
        $error("quotient: expected %h, actual %h", want.quotient, quotient);
        mismatches++;
      end
      if (dbz !== want.dbz) begin
        $error("divide_by_zero: expected %b, actual %b", want.dbz, dbz);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_ready;
  logic [DW-1:0]      in_dividend        = '0;
  logic [DW-1:0]      in_divisor         = '0;
  logic               in_value_negative  = 1'b0;
  logic               in_shift_enable    = 1'b0;
  logic [SHIFT_W-1:0] in_shift_amount    = '0;
  logic               out_valid;
  logic               out_ready          = 1'b0;
  logic [DW-1:0]      out_quotient;
  logic               out_divide_by_zero;
  logic               cfg_valid          = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_rounding_mode  = RM_NEAREST_EVEN;

  quotient_ledger ledger;
  bit             sender_steady   = 1'b0;
  bit             receiver_steady = 1'b0;
  int unsigned    results_seen    = 0;

  rounding_integer_divider #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_dividend       (in_dividend),
    .in_divisor        (in_divisor),
    .in_value_negative (in_value_negative),
    .in_shift_enable   (in_shift_enable),
    .in_shift_amount   (in_shift_amount),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_quotient      (out_quotient),
    .out_divide_by_zero(out_divide_by_zero),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_rounding_mode (cfg_rounding_mode)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [DW-1:0] rand_bits();
    return {$urandom, $urandom};
  endfunction

  function automatic operand_word_t pack_operands(logic [DW-1:0] dividend,
                                                  logic [DW-1:0] divisor, logic neg,
                                                  logic shen, logic [SHIFT_W-1:0] sh);
    operand_word_t w;
    w.dividend = dividend;
    w.divisor  = divisor;
    w.neg      = neg;
    w.shen     = shen;
    w.sh       = sh;
    return w;
  endfunction

  // Random operands. Most words are built as q * divisor + remainder with the
  // remainder zero, at or around the halfway point, one below the divisor or
  // random, so that every rounding decision is reached; the rest are raw noise,
  // near-full-width divisors and zero divisors.
  function automatic operand_word_t make_random_word();
    operand_word_t w;
    int unsigned   roll;
    int unsigned   dlen;
    int unsigned   qlen;
    logic [DW-1:0] q;
    logic [DW-1:0] r;
    w.neg  = 1'($urandom_range(0, 1));
    w.sh   = SHIFT_W'($urandom_range(0, 63));
    w.shen = ($urandom_range(0, 3) == 0);
    roll   = $urandom_range(0, 99);
    if (roll < 5) begin
      w.dividend = rand_bits();
      w.divisor  = '0;
    end else if (roll < 25) begin
      w.dividend = rand_bits() >> $urandom_range(0, 63);
      w.divisor  = rand_bits() >> $urandom_range(0, 63);
    end else if (roll < 37) begin
      // divisor with its top bit set: twice the remainder can need 65 bits
      w.shen     = 1'b0;
      w.divisor  = rand_bits() | {1'b1, {(DW-1){1'b0}}};
      case ($urandom_range(0, 2))
        0:       w.dividend = w.divisor >> 1;
        1:       w.dividend = w.divisor + (w.divisor >> 1);
        default: w.dividend = rand_bits();
      endcase
    end else begin
      dlen       = $urandom_range(1, 32);
      w.divisor  = (rand_bits() >> (DW - dlen)) | (64'd1 << (dlen - 1));
      qlen       = $urandom_range(0, 63 - dlen);
      q          = (qlen == 0) ? '0 : (rand_bits() >> (DW - qlen));
      case ($urandom_range(0, 4))
        0:       r = '0;
        1:       r = w.divisor >> 1;
        2:       r = (w.divisor >> 1) + 1;
        3:       r = w.divisor - 1;
        default: r = rand_bits() % w.divisor;
      endcase
      if (r >= w.divisor) begin
        r = '0;
      end
      w.dividend = q * w.divisor + r;
      // keep the built remainder intact most of the time
      if ($urandom_range(0, 7) != 0) begin
        w.shen = 1'b0;
      end
    end
    return w;
  endfunction

  // Offer one operand word and hold it until the block takes it. Valid stays
  // high straight into the next word when there is no gap.
  task automatic send_word(operand_word_t w);
    int unsigned gap;
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_dividend       <= w.dividend;
    in_divisor        <= w.divisor;
    in_value_negative <= w.neg;
    in_shift_enable   <= w.shen;
    in_shift_amount   <= w.sh;
    do @(posedge clk); while (!in_ready);
    ledger.note_operands(w);
  endtask

  // Drop valid and wait until every owed quotient has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.owed.size() != 0);
  endtask

  task automatic write_rounding_mode(logic [1:0] mode);
    cfg_valid         <= 1'b1;
    cfg_rounding_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    ledger.rounding_mode = mode;
    cfg_valid <= 1'b0;
  endtask

  // Result side: random back-pressure, and two long hold-offs while the sender
  // keeps offering, so the pipeline fills right up and in_ready drops.
  initial begin
    int unsigned gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (results_seen % 128 == 0) begin
        receiver_steady = ($urandom_range(0, 3) == 0);
      end
      if (results_seen == 100 || results_seen == 1000) begin
        gap = LONG_HOLD;
      end else begin
        gap = pick_gap(receiver_steady);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      ledger.check_quotient(out_quotient, out_divide_by_zero);
      results_seen++;
    end
  end

  initial begin
    operand_word_t directed[$];
    logic [1:0]    phase_mode[PHASES];
    ledger = new();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, run at the reset mode (nearest even)
    directed.push_back(pack_operands('0, 64'd1, 1'b0, 1'b0, '0));
    directed.push_back(pack_operands('1, 64'd1, 1'b1, 1'b0, '0));
    directed.push_back(pack_operands('1, '1, 1'b0, 1'b0, '1));
    // zero divisor, with and without a shift
    directed.push_back(pack_operands('0, '0, 1'b0, 1'b0, '0));
    directed.push_back(pack_operands('1, '0, 1'b1, 1'b1, 6'd5));
    // halfway: odd quotient goes up, even stays; then just below and above halfway
    directed.push_back(pack_operands(64'd7, 64'd2, 1'b0, 1'b0, '0));
    directed.push_back(pack_operands(64'd5, 64'd2, 1'b1, 1'b0, '0));
    directed.push_back(pack_operands(64'd7, 64'd3, 1'b0, 1'b0, '0));
    directed.push_back(pack_operands(64'd8, 64'd3, 1'b1, 1'b0, '0));
    // near-full-width divisors, twice the remainder up to 2^64: must not wrap
    directed.push_back(pack_operands(64'h8000_0000_0000_0000, '1, 1'b0, 1'b0, '0));
    directed.push_back(pack_operands(64'h7FFF_FFFF_FFFF_FFFF, '1, 1'b0, 1'b0, '0));
    directed.push_back(pack_operands(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                                     1'b0, 1'b0, '0));
    directed.push_back(pack_operands('1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0, '0));
    directed.push_back(pack_operands('1, 64'h8000_0000_0000_0001, 1'b0, 1'b0, '0));
    // shifts: bits pushed past the top are lost; a disabled shift is ignored
    directed.push_back(pack_operands(64'd1, 64'd3, 1'b0, 1'b1, 6'd63));
    directed.push_back(pack_operands(64'd3, 64'd3, 1'b1, 1'b1, 6'd63));
    directed.push_back(pack_operands('1, 64'd7, 1'b0, 1'b1, 6'd32));
    directed.push_back(pack_operands(64'd9, 64'd2, 1'b1, 1'b0, 6'd63));
    foreach (directed[k]) begin
      send_word(directed[k]);
    end
    drain();

    // Random phases, each under its own mode; every mode of the register once
    // and then two random picks
    phase_mode[0] = RM_TOWARD_ZERO;
    phase_mode[1] = RM_TOWARD_POS;
    phase_mode[2] = RM_TOWARD_NEG;
    phase_mode[3] = RM_NEAREST_EVEN;
    phase_mode[4] = 2'($urandom_range(0, 3));
    phase_mode[5] = 2'($urandom_range(0, 3));
    for (int p = 0; p < PHASES; p++) begin
      write_rounding_mode(phase_mode[p]);
      sender_steady = (p == 1) || ($urandom_range(0, 5) == 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(make_random_word());
      end
      drain();
    end

    // Let any stray word surface before judging
    repeat (DW + 8) @(posedge clk);
    if (ledger.owed.size() != 0) begin
      $error("%0d quotient words never arrived", ledger.owed.size());
    end
    if (ledger.mismatches == 0 && ledger.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
